[rtl/core/fba_pkg.sv]
// Shared constants, types and helpers for the frame bitmap allocator.
`default_nettype none
package fba_pkg;
	localparam int unsigned MAX_FRAMES_DEF = 65536;
	localparam int unsigned CNT_W = 17;
	localparam int unsigned START_W = 16;
	localparam int unsigned FRAME_W = 16;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_W = 17;
	localparam int unsigned WORD_W = 64;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BIG = 2'd2;

	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_SEARCH_START = 1'b1;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	// operation selected by the controller for the datapath
	localparam logic [1:0] OP_SINGLE = 2'd0;
	localparam logic [1:0] OP_GROUP = 2'd1;
	localparam logic [1:0] OP_FREE = 2'd2;

	typedef struct packed {
		logic       clear;      // clearing pass step
		logic       load;       // latch request, set up scan
		logic       rd;         // issue a memory read at the cursor
		logic       eval;       // read data valid: test it
		logic       wr_claim;   // write the claimed word
		logic       wr_free;    // write the free word
		logic       adv;        // move cursor to next word
		logic [1:0] op;
	} fba_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_range;     // cursor word still below the limit
		logic hit;          // evaluated word gives a result
		logic free_more;    // free run spills into the next word
	} fba_sts_t;
endpackage
`default_nettype wire

[rtl/core/fba_ctrl.sv]
// Controller state machine for the frame bitmap allocator.
`default_nettype none
module fba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              kind,
	input  wire logic [6:0]        count,
	input  wire logic              too_many,
	output logic                   busy,
	output logic                   fin,
	output logic                   fin_err,
	output logic                   fin_oom,
	output fba_pkg::fba_cmd_t      cmd,
	input  wire fba_pkg::fba_sts_t sts
);
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q, op_d;
	logic accept, bad, zero;

	assign accept = start && !busy;
	assign bad = too_many || (kind == fba_pkg::KIND_ALLOC && count > 7'd64);
	assign zero = kind == fba_pkg::KIND_ALLOC && count == 7'd0;
	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		cmd = '0;
		cmd.op = op_q;
		fin = 1'b0;
		fin_err = 1'b0;
		fin_oom = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (bad) begin
						fin = 1'b1;
						fin_err = 1'b1;
					end else if (zero) begin
						fin = 1'b1;
					end else begin
						op_d = (kind == fba_pkg::KIND_FREE) ? fba_pkg::OP_FREE :
							(count == 7'd1) ? fba_pkg::OP_SINGLE : fba_pkg::OP_GROUP;
						cmd.load = 1'b1;
						cmd.op = op_d;
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (!sts.in_range) begin
					fin = 1'b1;
					fin_oom = (op_q != fba_pkg::OP_FREE);
					state_d = S_IDLE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (op_q == fba_pkg::OP_FREE) begin
					cmd.wr_free = 1'b1;
					cmd.adv = 1'b1;
					if (sts.free_more) state_d = S_RD;
					else state_d = S_DONE;
				end else if (sts.hit) begin
					cmd.wr_claim = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_RD;
				end
			end
			S_DONE: begin
				fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			op_q <= fba_pkg::OP_SINGLE;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end
endmodule
`default_nettype wire

[rtl/core/fba_dp.sv]
// Datapath: bitmap memory, scan cursor and word tests.
`default_nettype none
module fba_dp #(
	parameter int unsigned MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire fba_pkg::fba_cmd_t            cmd,
	output fba_pkg::fba_sts_t                 sts,
	input  wire logic [fba_pkg::FRAME_W-1:0]  frame,
	input  wire logic [6:0]                   count,
	input  wire logic [fba_pkg::CNT_W-1:0]    frame_count,
	input  wire logic [fba_pkg::START_W-1:0]  search_start,
	output logic [fba_pkg::FRAME_W-1:0]       base_q
);
	localparam int unsigned WORDS = (MAX_FRAMES + 63) / 64;
	localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned LW = $clog2(MAX_FRAMES + 1) > fba_pkg::CNT_W ?
		$clog2(MAX_FRAMES + 1) : fba_pkg::CNT_W;
	localparam logic [LW-1:0] MAXF = LW'(MAX_FRAMES);
	localparam logic [LW-1:0] WORDS_L = LW'(WORDS);

	logic [63:0] mem [WORDS];
	logic [63:0] rdata_q;
	logic [LW-1:0] lim_q;      // frame limit
	logic [LW-1:0] wcur_q;     // cursor word index
	logic [LW-1:0] clr_q;
	logic [6:0] sz_q;
	logic [6:0] cnt_q;
	logic [5:0] boff_q;        // group / free bit offset in first word
	logic [7:0] rem_q;         // free: frames left
	logic [LW-1:0] lim_d, wfirst, wfree, frmL;
	logic [6:0] sz_d;
	logic [63:0] fmask, wdata, sing, cand, cmask;
	logic [5:0] pos, gbest;
	logic ghit, shit, found;
	logic [LW+6:0] fbase;
	logic [7:0] span;

	assign lim_d = ({{(LW-fba_pkg::CNT_W){1'b0}}, frame_count} < MAXF) ?
		{{(LW-fba_pkg::CNT_W){1'b0}}, frame_count} : MAXF;
	assign sz_d = (count > 7'd32) ? 7'd64 : (count > 7'd16) ? 7'd32 :
		(count > 7'd8) ? 7'd16 : 7'd8;
	assign frmL = LW'(frame);
	assign wfirst = LW'(search_start[fba_pkg::START_W-1:6]);

	// single: lowest free bit in word, below the limit
	always_comb begin
		sing = ~rdata_q;
		for (int i = 0; i < 64; i++) begin
			if ({wcur_q[LW-7:0], 6'(i)} >= lim_q) sing[i] = 1'b0;
		end
		shit = |sing;
		pos = '0;
		for (int i = 63; i >= 0; i--) if (sing[i]) pos = 6'(i);
	end

	// group: test each aligned group of sz within the word
	always_comb begin
		ghit = 1'b0;
		gbest = '0;
		cand = '0;
		for (int g = 7; g >= 0; g--) begin
			cand = (sz_q == 7'd64) ? '1 : ((64'd1 << sz_q) - 64'd1);
			cand = cand << (g * 8);
			if ((6'(g * 8) >= boff_q)
			    && ((6'(g * 8) & (sz_q[5:0] - 6'd1)) == 6'd0)
			    && (7'(g * 8) + sz_q <= 7'd64)
			    && ({1'b0, wcur_q[LW-7:0], 6'(g * 8)} + (LW+1)'(sz_q) <= {1'b0, lim_q})
			    && ((rdata_q & cand) == 64'd0)) begin
				ghit = 1'b1;
				gbest = 6'(g * 8);
			end
		end
	end

	// free: bits from boff across min(rem, 64-boff)
	always_comb begin
		span = 8'd64 - {2'b0, boff_q};
		if (rem_q < span) span = rem_q;
		fmask = (span == 8'd64) ? '1 : ((64'd1 << span[6:0]) - 64'd1);
		fmask = fmask << boff_q;
	end

	assign found = (cmd.op == fba_pkg::OP_SINGLE) ? shit : ghit;
	assign wfree = frmL >> 6;

	always_comb begin
		sts.clear_done = (clr_q == WORDS_L - LW'(1));
		sts.in_range = (cmd.op == fba_pkg::OP_FREE) ? (wcur_q < WORDS_L) :
			({wcur_q, 6'd0} < {6'd0, lim_q});
		sts.hit = found;
		sts.free_more = (rem_q > span) && (wcur_q + LW'(1) < WORDS_L);
	end

	always_comb begin
		wdata = rdata_q;
		cmask = '0;
		if (cmd.op == fba_pkg::OP_FREE) wdata = rdata_q & ~fmask;
		else if (cmd.op == fba_pkg::OP_SINGLE) wdata = rdata_q | (64'd1 << pos);
		else begin
			// claim group, surplus beyond count stays free
			cmask = (cnt_q == 7'd64) ? '1 : ((64'd1 << cnt_q) - 64'd1);
			wdata = rdata_q | (cmask << gbest);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_q[AW-1:0]] <= '1;
		else if (cmd.wr_claim || cmd.wr_free) mem[wcur_q[AW-1:0]] <= wdata;
		if (cmd.rd) rdata_q <= mem[wcur_q[AW-1:0]];
	end

	assign fbase = {wcur_q, 6'd0} + (LW+7)'(cmd.op == fba_pkg::OP_SINGLE ? pos : gbest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !sts.clear_done) begin
			clr_q <= clr_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lim_q <= lim_d;
			sz_q <= sz_d;
			cnt_q <= count;
			base_q <= '0;
			if (cmd.op == fba_pkg::OP_FREE) begin
				wcur_q <= wfree;
				boff_q <= frame[5:0];
				rem_q <= {1'b0, count};
			end else begin
				wcur_q <= wfirst;
				boff_q <= (cmd.op == fba_pkg::OP_GROUP) ?
					(search_start[5:0] & ~(sz_d[5:0] - 6'd1)) : 6'd0;
				rem_q <= '0;
			end
		end else if (cmd.eval) begin
			if (cmd.wr_claim) base_q <= fbase[fba_pkg::FRAME_W-1:0];
			if (cmd.adv) begin
				wcur_q <= wcur_q + LW'(1);
				if (cmd.op == fba_pkg::OP_FREE) rem_q <= rem_q - span;
				boff_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/frame_bitmap_allocator_top.sv]
// Errors and zero-count allocations finish straight from idle; other requests scan the bitmap word by word.
// Throughput: one request at a time; busy held until the result strobe.
// Single-frame or group scans test one 64-frame word per step; a free <= 3 words.
// Reset: a clearing pass over every bitmap word sets every frame used; busy meanwhile.
// Results hold one cycle under result_valid; the receiver cannot stall.
`default_nettype none
module frame_bitmap_allocator_top #(
	parameter int unsigned MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          kind,
	input  wire logic [fba_pkg::FRAME_W-1:0]   frame,
	input  wire logic [fba_pkg::COUNT_W-1:0]   count,
	input  wire logic                          too_many,
	output logic                               result_valid,
	output logic [fba_pkg::FRAME_W-1:0]        base_frame,
	output logic [fba_pkg::STATUS_W-1:0]       status,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [fba_pkg::CFG_W-1:0]     cfg_data
);
	fba_pkg::fba_cmd_t cmd;
	fba_pkg::fba_sts_t sts;
	logic fin, fin_err, fin_oom;
	logic [fba_pkg::CNT_W-1:0] frame_count_q;
	logic [fba_pkg::START_W-1:0] search_start_q;
	logic [fba_pkg::FRAME_W-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= fba_pkg::CNT_W'(65536);
			search_start_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == fba_pkg::REG_FRAME_COUNT) frame_count_q <= cfg_data;
			else search_start_q <= cfg_data[fba_pkg::START_W-1:0];
		end
	end

	fba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind), .count(count),
		.too_many(too_many), .busy(busy), .fin(fin), .fin_err(fin_err),
		.fin_oom(fin_oom), .cmd(cmd), .sts(sts)
	);

	fba_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .frame(frame),
		.count(count), .frame_count(frame_count_q), .search_start(search_start_q),
		.base_q(base_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			status <= fba_pkg::ST_OK;
			base_frame <= '0;
		end else begin
			result_valid <= fin;
			if (fin) begin
				status <= fin_err ? fba_pkg::ST_BIG : fin_oom ? fba_pkg::ST_OOM : fba_pkg::ST_OK;
				base_frame <= (fin_err || fin_oom || busy == 1'b0) ? '0 : base_q;
			end
		end
	end
endmodule
`default_nettype wire
